[rtl/gbpf_pkg.sv]
// shared types and constants for the grid path finder
`timescale 1ns / 1ps
`default_nettype none
package gbpf_pkg;
    localparam int GRID_WIDTH  = 8;
    localparam int GRID_HEIGHT = 8;
    localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
    localparam int CW          = $clog2(CELLS);
    localparam int CNTW        = $clog2(CELLS + 1);

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_E = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [2:0] cell_x;
        logic [2:0] cell_y;
        logic       walkable;
        logic [2:0] start_x;
        logic [2:0] start_y;
        logic [2:0] target_x;
        logic [2:0] target_y;
    } t_in;

    typedef struct packed {
        logic       found;
        logic [2:0] path_x;
        logic [2:0] path_y;
        logic       last;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item
        logic map_wr;    // write walk map
        logic clr;       // clear visited, seed queue
        logic deq;       // pop queue head into current cell
        logic nbr;       // evaluate neighbor r_dir
        logic bt_init;   // start back walk
        logic bt_step;   // one back step
        logic emit;      // pop route stack to output
        logic emit_none;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad;       // start or target outside the grid, or same cell
        logic q_empty;
        logic reached;
        logic dir_last;  // neighbor step at west
        logic at_start;  // back walk reached start
        logic stk_last;  // one entry left on the stack
    } t_sts;

    function automatic logic [CW-1:0] cell_idx(input logic [2:0] x, input logic [2:0] y);
        return CW'(32'(y) * GRID_WIDTH + 32'(x));
    endfunction
endpackage
`default_nettype wire

[rtl/gbpf_datapath.sv]
// map, queue, parent and route stores with the neighbor and back walk logic
`timescale 1ns / 1ps
`default_nettype none
module gbpf_datapath import gbpf_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_in  i_item,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_res,
    output logic o_res_valid
);
    logic [CELLS-1:0] r_walk, r_vis;
    logic [1:0]  r_par [CELLS];
    logic [CW-1:0] r_queue [CELLS];
    logic [CW-1:0] r_stack [CELLS];
    t_in r_it;
    logic [CNTW-1:0] r_head, r_tail, r_sp;
    logic [2:0] r_cx, r_cy;
    logic [1:0] r_dir;
    logic r_reached;
    logic [CW-1:0] r_cur;
    logic [1:0] r_pdir;
    logic [2:0] r_bx, r_by;
    t_out r_res;
    logic r_res_valid;

    logic [CW-1:0] w_start, w_tgt;
    logic       w_ok;
    logic [2:0] w_nx, w_ny;
    logic [CW-1:0] w_ni;
    logic [2:0] w_px, w_py;

    assign w_start = cell_idx(r_it.start_x, r_it.start_y);
    assign w_tgt   = cell_idx(r_it.target_x, r_it.target_y);

    always_comb begin
        w_nx = r_cx;
        w_ny = r_cy;
        w_ok = 1'b0;
        case (r_dir)
            DIR_N: begin w_ok = 32'(r_cy) + 1 < GRID_HEIGHT; w_ny = r_cy + 3'd1; end
            DIR_S: begin w_ok = r_cy != 3'd0; w_ny = r_cy - 3'd1; end
            DIR_E: begin w_ok = 32'(r_cx) + 1 < GRID_WIDTH; w_nx = r_cx + 3'd1; end
            default: begin w_ok = r_cx != 3'd0; w_nx = r_cx - 3'd1; end
        endcase
        w_ni = cell_idx(w_nx, w_ny);
    end

    // undo the move that queued the current back walk cell
    always_comb begin
        w_px = r_bx;
        w_py = r_by;
        case (r_pdir)
            DIR_N: w_py = r_by - 3'd1;
            DIR_S: w_py = r_by + 3'd1;
            DIR_E: w_px = r_bx - 3'd1;
            default: w_px = r_bx + 3'd1;
        endcase
    end

    assign o_sts.bad = (32'(r_it.start_x) >= GRID_WIDTH) || (32'(r_it.start_y) >= GRID_HEIGHT)
                    || (32'(r_it.target_x) >= GRID_WIDTH) || (32'(r_it.target_y) >= GRID_HEIGHT)
                    || (w_start == w_tgt);
    assign o_sts.q_empty  = r_head == r_tail;
    assign o_sts.reached  = r_reached;
    assign o_sts.dir_last = r_dir == DIR_W;
    assign o_sts.at_start = r_cur == w_start;
    assign o_sts.stk_last = r_sp == CNTW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_it <= i_item;
        if (!i_rst_n) begin
            r_walk <= '0;
        end else if (i_cmd.map_wr && 32'(i_item.cell_x) < GRID_WIDTH
                     && 32'(i_item.cell_y) < GRID_HEIGHT) begin
            r_walk[cell_idx(i_item.cell_x, i_item.cell_y)] <= i_item.walkable;
        end
        if (!i_rst_n) begin
            r_vis <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_reached <= 1'b0;
            r_sp <= '0;
            r_dir <= DIR_N;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.emit || i_cmd.emit_none;
            if (i_cmd.clr) begin
                r_vis <= CELLS'(1) << w_start;
                r_queue[0] <= w_start;
                r_head <= '0;
                r_tail <= CNTW'(1);
                r_reached <= 1'b0;
                r_sp <= '0;
            end
            if (i_cmd.deq) begin
                r_cx <= 3'(32'(r_queue[r_head[CW-1:0]]) % GRID_WIDTH);
                r_cy <= 3'(32'(r_queue[r_head[CW-1:0]]) / GRID_WIDTH);
                r_head <= r_head + CNTW'(1);
                r_dir <= DIR_N;
            end
            if (i_cmd.nbr) begin
                r_dir <= r_dir + 2'd1;
                if (w_ok && !r_vis[w_ni] && r_walk[w_ni]) begin
                    r_vis[w_ni] <= 1'b1;
                    r_par[w_ni] <= r_dir;
                    if (32'(r_tail) < CELLS) begin
                        r_queue[r_tail[CW-1:0]] <= w_ni;
                        r_tail <= r_tail + CNTW'(1);
                    end
                    if (w_ni == w_tgt) r_reached <= 1'b1;
                end
            end
            // parent direction is fetched along with the cell it belongs to
            if (i_cmd.bt_init) begin
                r_cur <= w_tgt;
                r_pdir <= r_par[w_tgt];
                r_bx <= r_it.target_x;
                r_by <= r_it.target_y;
            end
            if (i_cmd.bt_step) begin
                r_cur <= cell_idx(w_px, w_py);
                r_pdir <= r_par[cell_idx(w_px, w_py)];
                r_bx <= w_px;
                r_by <= w_py;
                r_stack[r_sp[CW-1:0]] <= cell_idx(w_px, w_py);
                r_sp <= r_sp + CNTW'(1);
            end
            if (i_cmd.emit) begin
                r_res.found  <= 1'b1;
                r_res.path_x <= 3'(32'(r_stack[CW'(r_sp - CNTW'(1))]) % GRID_WIDTH);
                r_res.path_y <= 3'(32'(r_stack[CW'(r_sp - CNTW'(1))]) / GRID_WIDTH);
                r_res.last   <= r_sp == CNTW'(1);
                r_sp <= r_sp - CNTW'(1);
            end
            if (i_cmd.emit_none) begin
                r_res <= '{found: 1'b0, path_x: 3'd0, path_y: 3'd0, last: 1'b1};
            end
        end
    end

    assign o_res = r_res;
    assign o_res_valid = r_res_valid;
endmodule
`default_nettype wire

[rtl/gbpf_ctrl.sv]
// sequencer for map writes and searches
`timescale 1ns / 1ps
`default_nettype none
module gbpf_ctrl import gbpf_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_go,
    input  wire  i_op,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_DEQ  = 7'b0000100,
        S_NBR  = 7'b0001000,
        S_BT   = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_NONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    o_cmd.load = 1'b1;
                    if (i_op == OP_SEARCH) n_state = S_CHK;
                    else o_cmd.map_wr = 1'b1;
                end
            end
            S_CHK: begin
                if (i_sts.bad) n_state = S_NONE;
                else begin
                    o_cmd.clr = 1'b1;
                    n_state = S_DEQ;
                end
            end
            S_DEQ: begin
                if (i_sts.reached) begin
                    o_cmd.bt_init = 1'b1;
                    n_state = S_BT;
                end else if (i_sts.q_empty) n_state = S_NONE;
                else begin
                    o_cmd.deq = 1'b1;
                    n_state = S_NBR;
                end
            end
            S_NBR: begin
                if (i_sts.reached) begin
                    o_cmd.bt_init = 1'b1;
                    n_state = S_BT;
                end else begin
                    o_cmd.nbr = 1'b1;
                    if (i_sts.dir_last) n_state = S_DEQ;
                end
            end
            S_BT: begin
                if (i_sts.at_start) n_state = S_EMIT;
                else o_cmd.bt_step = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.stk_last) n_state = S_IDLE;
            end
            S_NONE: begin
                o_cmd.emit_none = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_busy = r_state != S_IDLE;
endmodule
`default_nettype wire

[rtl/grid_bfs_path_finder.sv]
// top level of the grid shortest path finder
// usage:
// - drive i_item and raise start while busy is low; the beat is taken then
// - opcode 0 writes one walk map bit at that edge and gives no result; busy
//   stays low
// - opcode 1 runs a breadth-first search over the 8x8 map from start to
//   target, north, south, east, west order, then walks parents back
// - results come out one per cycle on o_result with o_result_valid high for
//   one cycle, start cell first, last set on the final beat
// - unreachable, out of grid or start equal to target give one beat found=0
// - a search runs a check step, then for each dequeued cell a dequeue step and
//   four neighbor checks on one shared neighbor unit, a step that sees the
//   target, back walk steps along the path and an emit step per beat; each
//   beat shows the cycle after its emit cycle
// - busy is high from the edge after a search beat until the final beat shows
// - the receiver cannot stall; every beat must be taken when shown
// - reset clears the walk map to all blocked and returns to idle
`timescale 1ns / 1ps
`default_nettype none
module grid_bfs_path_finder import gbpf_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    input  t_in  i_item,
    output t_out o_result,
    output logic o_result_valid
);
    t_cmd w_cmd;
    t_sts w_sts;

    gbpf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(start), .i_op(i_item.opcode),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(busy)
    );

    gbpf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_res(o_result), .o_res_valid(o_result_valid)
    );

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w_cmd.load) else $error("item taken while busy");
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit || w_cmd.emit_none) |-> busy) else $error("result while idle");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last) |-> !busy) else $error("busy after last");
endmodule
`default_nettype wire

[tb/grid_bfs_path_finder_checker.sv]
// path checker: watches map, search and result beats, predicts routes, compares
`timescale 1ns / 1ps
`default_nettype none
module grid_bfs_path_finder_checker import gbpf_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    input  wire  busy,
    input  t_in  i_item,
    input  t_out o_result,
    input  wire  o_result_valid,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_routes_seen
);
    logic walk_grid [CELLS];
    t_out route_q [$];

    // breadth-first search over the mirrored map, queues the expected beats
    task automatic predict_route(input t_in it);
        logic         seen [CELLS];
        logic [1:0]   from_dir [CELLS];
        int           fifo [$];
        int           trail [$];
        int           src, dst, cur, x, y, nx, ny, ni;
        logic         hit;
        t_out         r;
        src = int'(it.start_y) * GRID_WIDTH + int'(it.start_x);
        dst = int'(it.target_y) * GRID_WIDTH + int'(it.target_x);
        hit = 1'b0;
        foreach (seen[k]) seen[k] = 1'b0;
        seen[src] = 1'b1;
        fifo = {fifo, src};
        while (fifo.size() > 0 && !hit) begin
            cur = fifo.pop_front();
            x = cur % GRID_WIDTH;
            y = cur / GRID_WIDTH;
            for (int d = 0; d < 4 && !hit; d++) begin
                nx = x;
                ny = y;
                if (2'(d) == DIR_N) ny = y + 1;
                else if (2'(d) == DIR_S) ny = y - 1;
                else if (2'(d) == DIR_E) nx = x + 1;
                else nx = x - 1;
                if (nx < 0 || ny < 0 || nx >= GRID_WIDTH || ny >= GRID_HEIGHT) continue;
                ni = ny * GRID_WIDTH + nx;
                if (seen[ni] || !walk_grid[ni]) continue;
                seen[ni] = 1'b1;
                from_dir[ni] = 2'(d);
                fifo = {fifo, ni};
                if (ni == dst) hit = 1'b1;
            end
        end
        if (!hit) begin
            r = '{found: 1'b0, path_x: 3'd0, path_y: 3'd0, last: 1'b1};
            route_q = {route_q, r};
            return;
        end
        cur = dst;
        while (cur != src) begin
            x = cur % GRID_WIDTH;
            y = cur / GRID_WIDTH;
            case (from_dir[cur])
                DIR_N: y = y - 1;
                DIR_S: y = y + 1;
                DIR_E: x = x - 1;
                default: x = x + 1;
            endcase
            cur = y * GRID_WIDTH + x;
            trail.push_front(cur);
        end
        foreach (trail[k]) begin
            r.found  = 1'b1;
            r.path_x = 3'(trail[k] % GRID_WIDTH);
            r.path_y = 3'(trail[k] / GRID_WIDTH);
            r.last   = (k == trail.size() - 1);
            route_q = {route_q, r};
        end
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            foreach (walk_grid[k]) walk_grid[k] <= 1'b0;
            o_fail_count  <= 0;
            o_routes_seen <= 0;
            o_pending     <= 0;
        end else begin
            if (o_result_valid) begin
                if (route_q.size() == 0) begin
                    $error("result beat with nothing expected: %p", o_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = route_q.pop_front();
                    if (e.found !== o_result.found)
                        $error("found: expected %0d got %0d", e.found, o_result.found);
                    if (e.path_x !== o_result.path_x)
                        $error("path_x: expected %0d got %0d", e.path_x, o_result.path_x);
                    if (e.path_y !== o_result.path_y)
                        $error("path_y: expected %0d got %0d", e.path_y, o_result.path_y);
                    if (e.last !== o_result.last)
                        $error("last: expected %0d got %0d", e.last, o_result.last);
                    if (e !== o_result) o_fail_count <= o_fail_count + 1;
                    if (e.last && e.found) o_routes_seen <= o_routes_seen + 1;
                end
            end
            // a beat launched here is checked from the next edge on
            if (start && !busy) begin
                if (i_item.opcode == OP_LOAD)
                    walk_grid[cell_idx(i_item.cell_x, i_item.cell_y)] <= i_item.walkable;
                else
                    predict_route(i_item);
            end
            o_pending <= route_q.size();
        end
    end
endmodule
`default_nettype wire

[tb/grid_bfs_path_finder_test.sv]
// stimulus and verdict for the grid path finder
`timescale 1ns / 1ps
`default_nettype none
module grid_bfs_path_finder_test;
    import gbpf_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_in  i_item = '0;
    logic busy;
    t_out o_result;
    logic o_result_valid;
    int   fail_count, pending, routes_seen;
    int   idle_cycles = 0;
    int   searches = 0, loads = 0;

    grid_bfs_path_finder i_dut (.*);
    grid_bfs_path_finder_checker i_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_result, .o_result_valid,
        .o_fail_count(fail_count), .o_pending(pending), .o_routes_seen(routes_seen)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("grid_bfs_path_finder test failed");
            $finish;
        end
    end

    task automatic send_beat(input t_in it);
        @(negedge i_clk);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start <= 1'b0;
        if (it.opcode == OP_SEARCH) searches++;
        else loads++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic load_cell(input int x, input int y, input logic w);
        t_in it;
        it = t_in'($bits(t_in)'($urandom()));
        it.opcode = OP_LOAD;
        it.cell_x = 3'(x);
        it.cell_y = 3'(y);
        it.walkable = w;
        send_beat(it);
    endtask

    task automatic search(input int sx, input int sy, input int tx, input int ty);
        t_in it;
        it = t_in'($bits(t_in)'($urandom()));
        it.opcode = OP_SEARCH;
        it.start_x = 3'(sx);
        it.start_y = 3'(sy);
        it.target_x = 3'(tx);
        it.target_y = 3'(ty);
        send_beat(it);
    endtask

    initial begin
        int wait_cycles;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty map, start equals target, corner to corner
        search(0, 0, 7, 7);
        load_cell(7, 7, 1'b1);
        search(3, 3, 3, 3);
        search(0, 0, 7, 7);
        // open a row and a column, reach the far corner, blocked start walks on
        for (int k = 0; k < 8; k++) load_cell(k, 0, 1'b1);
        for (int k = 1; k < 8; k++) load_cell(7, k, 1'b1);
        search(0, 0, 7, 7);
        search(7, 7, 0, 0);
        load_cell(0, 0, 1'b0);
        search(0, 0, 1, 0);
        search(0, 7, 7, 7);
        search(7, 7, 0, 7);

        // full pause until all beats come back
        while (pending != 0) @(negedge i_clk);

        // random: dense maps mostly, with searches mixed in
        for (int n = 0; n < 230; n++) begin
            idle_gap();
            if ($urandom_range(0, 2) == 0)
                search($urandom_range(0, 7), $urandom_range(0, 7),
                       $urandom_range(0, 7), $urandom_range(0, 7));
            else
                load_cell($urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 3) != 0);
        end

        wait_cycles = 0;
        while ((pending != 0 || busy) && wait_cycles < STALL_LIMIT) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(negedge i_clk);
        $display("covered %0d map writes and %0d searches, %0d routes found",
                 loads, searches, routes_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("grid_bfs_path_finder test passed");
        end else begin
            $display("grid_bfs_path_finder test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[grid_bfs_path_finder.f]
rtl/gbpf_pkg.sv
rtl/gbpf_datapath.sv
rtl/gbpf_ctrl.sv
rtl/grid_bfs_path_finder.sv
tb/grid_bfs_path_finder_checker.sv
tb/grid_bfs_path_finder_test.sv
